/* rtl/fca_pkg.sv */
// ----------------------------------------------------------------------------
// fca_pkg
// Types and constants shared by the chain allocator front end, table
// engine and top level.
// ----------------------------------------------------------------------------
package fca_pkg;

	localparam logic [15:0] END_MARK = 16'hFFFF;
	localparam logic [13:0] ACTIVE_RESET = 14'd8192;
	localparam logic REG_ACTIVE_ENTRIES = 1'b0;
	localparam int CMD_DEPTH = 2;
	localparam int RES_DEPTH = 2;

	typedef enum logic [2:0] {
		OP_WRITE  = 3'd0,
		OP_READ   = 3'd1,
		OP_SEEK   = 3'd2,
		OP_APPEND = 3'd3,
		OP_FREE   = 3'd4,
		OP_COUNT  = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		K_NOP,
		K_WRITE,
		K_READ,
		K_SEEK,
		K_APPEND,
		K_FREE,
		K_COUNT
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_EARLY = 2'd3
	} status_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] blk;
		logic [15:0] hops;
		logic [15:0] val;
		logic        blk_ok;
		logic        blk_end;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] block_result;
		logic [15:0] new_head;
		logic [13:0] free_entries;
	} res_t;

endpackage

/* rtl/fca_queue.sv */
// ----------------------------------------------------------------------------
// fca_queue
// Small first-in first-out queue of register entries; the head entry is
// presented combinationally.
// ----------------------------------------------------------------------------
module fca_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == FULL_COUNT);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* rtl/fca_front.sv */
// ----------------------------------------------------------------------------
// fca_front
// Input side: accepts items, decodes the opcode and classifies the block
// index before the command enters the queue.
// ----------------------------------------------------------------------------
module fca_front import fca_pkg::*; #(
	parameter int TABLE_ENTRIES = 8192
) (
	input  logic        push,
	input  logic [2:0]  opcode,
	input  logic [15:0] block_index,
	input  logic [15:0] hop_count,
	input  logic [15:0] entry_value,
	input  logic        q_full,
	output logic        full,
	output logic        q_push,
	output cmd_t        cmd
);

	localparam logic [16:0] TE17 = 17'(TABLE_ENTRIES);

	kind_t kind;

	always_comb begin
		case (op_t'(opcode))
			OP_WRITE:  kind = K_WRITE;
			OP_READ:   kind = K_READ;
			OP_SEEK:   kind = K_SEEK;
			OP_APPEND: kind = K_APPEND;
			OP_FREE:   kind = K_FREE;
			OP_COUNT:  kind = K_COUNT;
			default:   kind = K_NOP;
		endcase
	end

	assign full        = q_full;
	assign q_push      = push && !q_full;
	assign cmd.kind    = kind;
	assign cmd.blk     = block_index;
	assign cmd.hops    = hop_count;
	assign cmd.val     = entry_value;
	assign cmd.blk_ok  = ({1'b0, block_index} < TE17);
	assign cmd.blk_end = (block_index == END_MARK);

endmodule

/* rtl/fca_engine.sv */
// ----------------------------------------------------------------------------
// fca_engine
// Back end: holds the link table memory and carries out one command at a
// time: single-entry writes and reads, chain walks, or table scans one entry per read.
// ----------------------------------------------------------------------------
module fca_engine import fca_pkg::*; #(
	parameter int TABLE_ENTRIES = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [13:0] active_entries,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_pop,
	input  logic        res_room,
	output logic        res_push,
	output res_t        res
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [16:0]   TE17 = 17'(TABLE_ENTRIES);
	localparam logic [CW-1:0] TE_C = CW'(TABLE_ENTRIES);

	typedef enum logic [11:0] {
		S_IDLE     = 12'b000000000001,
		S_RDWAIT   = 12'b000000000010,
		S_SEEK     = 12'b000000000100,
		S_SEEKWAIT = 12'b000000001000,
		S_SCAN     = 12'b000000010000,
		S_ALLOC    = 12'b000000100000,
		S_WALK     = 12'b000001000000,
		S_WALKWAIT = 12'b000010000000,
		S_LINK     = 12'b000100000000,
		S_FREE     = 12'b001000000000,
		S_FREEWAIT = 12'b010000000000,
		S_RESP     = 12'b100000000000
	} state_t;

	logic [15:0]   link_mem_q [TABLE_ENTRIES];
	logic [15:0]   rdata_q;
	state_t        state_q;
	state_t        state_d;
	res_t          res_q;
	kind_t         kind_q;
	logic [15:0]   blk_q;
	logic          blk_ok_q;
	logic          blk_end_q;
	logic [15:0]   cur_q;
	logic [15:0]   hop_q;
	logic [CW-1:0] walk_q;
	logic [CW-1:0] scan_q;
	logic [13:0]   cnt_q;
	logic          found_q;
	logic [IW-1:0] nxt_q;
	logic          rv_s1;
	logic [IW-1:0] idx_s1;

	logic          start;
	logic          rd_en;
	logic [IW-1:0] raddr;
	logic          we;
	logic [IW-1:0] waddr;
	logic [15:0]   wdata;
	logic [IW-1:0] cur_idx;
	logic          cur_ok;
	logic          cur_end;
	logic          rdata_ok;
	logic          rdata_end;
	logic          rdata_zero;
	logic          hop_zero;
	logic          walk_full;
	logic          is_append;
	logic [16:0]   act17;
	logic [16:0]   lim17;
	logic [CW-1:0] lim;
	logic          scan_more;

	assign start      = cmd_valid && res_room && (state_q == S_IDLE);
	assign cur_idx    = cur_q[IW-1:0];
	assign cur_ok     = ({1'b0, cur_q} < TE17);
	assign cur_end    = (cur_q == END_MARK);
	assign rdata_ok   = ({1'b0, rdata_q} < TE17);
	assign rdata_end  = (rdata_q == END_MARK);
	assign rdata_zero = (rdata_q == '0);
	assign hop_zero   = (hop_q == '0);
	assign walk_full  = (walk_q == TE_C);
	assign is_append  = (kind_q == K_APPEND);
	assign act17      = {3'b000, active_entries};
	assign lim17      = (act17 < TE17) ? act17 : TE17;
	assign lim        = lim17[CW-1:0];
	assign scan_more  = (scan_q < lim);
	assign res        = res_q;

	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		raddr    = cur_idx;
		we       = 1'b0;
		waddr    = cur_idx;
		wdata    = '0;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_pop = 1'b1;
					case (cmd.kind)
						K_WRITE: begin
							if (cmd.blk_ok) begin
								we    = 1'b1;
								waddr = cmd.blk[IW-1:0];
								wdata = cmd.val;
							end
							state_d = S_RESP;
						end
						K_READ: begin
							if (cmd.blk_ok) begin
								rd_en   = 1'b1;
								raddr   = cmd.blk[IW-1:0];
								state_d = S_RDWAIT;
							end else begin
								state_d = S_RESP;
							end
						end
						K_SEEK:   state_d = S_SEEK;
						K_APPEND: state_d = S_SCAN;
						K_COUNT:  state_d = S_SCAN;
						K_FREE:   state_d = cmd.blk_end ? S_RESP : S_FREE;
						default:  state_d = S_RESP;
					endcase
				end
			end
			S_RDWAIT: state_d = S_RESP;
			S_SEEK: begin
				if (hop_zero || cur_end || !cur_ok) begin
					state_d = S_RESP;
				end else begin
					rd_en   = 1'b1;
					state_d = S_SEEKWAIT;
				end
			end
			S_SEEKWAIT: state_d = S_SEEK;
			S_SCAN: begin
				if (scan_more) begin
					rd_en = 1'b1;
					raddr = scan_q[IW-1:0];
				end
				if (is_append && rv_s1 && rdata_zero) begin
					state_d = S_ALLOC;
				end else if (!rv_s1 && !scan_more) begin
					state_d = is_append ? S_ALLOC : S_RESP;
				end
			end
			S_ALLOC: begin
				if (!found_q || nxt_q == '0) begin
					state_d = S_RESP;
				end else if (blk_end_q) begin
					we      = 1'b1;
					waddr   = nxt_q;
					wdata   = END_MARK;
					state_d = S_RESP;
				end else if (!blk_ok_q) begin
					state_d = S_RESP;
				end else begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (walk_full) begin
					state_d = S_RESP;
				end else begin
					rd_en   = 1'b1;
					state_d = S_WALKWAIT;
				end
			end
			S_WALKWAIT: begin
				if (rdata_end) begin
					we      = 1'b1;
					wdata   = 16'(nxt_q);
					state_d = S_LINK;
				end else if (!rdata_ok) begin
					state_d = S_RESP;
				end else begin
					state_d = S_WALK;
				end
			end
			S_LINK: begin
				we      = 1'b1;
				waddr   = nxt_q;
				wdata   = END_MARK;
				state_d = S_RESP;
			end
			S_FREE: begin
				if (walk_full || !cur_ok) begin
					state_d = S_RESP;
				end else begin
					rd_en   = 1'b1;
					state_d = S_FREEWAIT;
				end
			end
			S_FREEWAIT: begin
				we      = 1'b1;
				state_d = rdata_end ? S_RESP : S_FREE;
			end
			S_RESP: begin
				res_push = 1'b1;
				state_d  = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					kind_q                <= cmd.kind;
					blk_q                 <= cmd.blk;
					blk_ok_q              <= cmd.blk_ok;
					blk_end_q             <= cmd.blk_end;
					cur_q                 <= cmd.blk;
					hop_q                 <= cmd.hops;
					walk_q                <= '0;
					scan_q                <= '0;
					cnt_q                 <= '0;
					found_q               <= 1'b0;
					rv_s1                 <= 1'b0;
					res_q.status          <= (!cmd.blk_ok &&
						(cmd.kind == K_WRITE || cmd.kind == K_READ)) ? ST_RANGE : ST_OK;
					res_q.block_result    <= '0;
					res_q.new_head        <= (cmd.kind == K_APPEND) ? cmd.blk : '0;
					res_q.free_entries    <= '0;
				end
			end
			S_RDWAIT: res_q.block_result <= rdata_q;
			S_SEEK: begin
				if (hop_zero) begin
					res_q.status       <= (!cur_end && !cur_ok) ? ST_RANGE : ST_OK;
					res_q.block_result <= cur_q;
				end else if (cur_end) begin
					res_q.status       <= ST_EARLY;
					res_q.block_result <= cur_q;
				end else if (!cur_ok) begin
					res_q.status       <= ST_RANGE;
					res_q.block_result <= cur_q;
				end else begin
					hop_q <= hop_q - 16'd1;
				end
			end
			S_SEEKWAIT: cur_q <= rdata_q;
			S_SCAN: begin
				rv_s1  <= scan_more;
				idx_s1 <= scan_q[IW-1:0];
				if (scan_more) begin
					scan_q <= scan_q + CW'(1);
				end
				if (rv_s1 && rdata_zero) begin
					found_q <= 1'b1;
					nxt_q   <= idx_s1;
					cnt_q   <= cnt_q + 14'd1;
				end
				if (!rv_s1 && !scan_more && !is_append) begin
					res_q.free_entries <= cnt_q;
				end
			end
			S_ALLOC: begin
				if (!found_q || nxt_q == '0) begin
					res_q.status <= ST_FULL;
				end else if (blk_end_q) begin
					res_q.block_result <= 16'(nxt_q);
					res_q.new_head     <= 16'(nxt_q);
				end else if (!blk_ok_q) begin
					res_q.status <= ST_RANGE;
				end else begin
					cur_q  <= blk_q;
					walk_q <= '0;
				end
			end
			S_WALK: begin
				if (walk_full) begin
					res_q.status <= ST_RANGE;
				end else begin
					walk_q <= walk_q + CW'(1);
				end
			end
			S_WALKWAIT: begin
				if (!rdata_end) begin
					if (!rdata_ok) begin
						res_q.status <= ST_RANGE;
					end else begin
						cur_q <= rdata_q;
					end
				end
			end
			S_LINK: res_q.block_result <= 16'(nxt_q);
			S_FREE: begin
				if (walk_full || !cur_ok) begin
					res_q.status <= ST_RANGE;
				end else begin
					walk_q <= walk_q + CW'(1);
				end
			end
			S_FREEWAIT: begin
				if (!rdata_end) begin
					cur_q <= rdata_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			link_mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= link_mem_q[raddr];
		end
	end

endmodule

/* rtl/fat_chain_allocator.sv */
// ----------------------------------------------------------------------------
// fat_chain_allocator
// File allocation table of next-block links with entry write and read, chain seek,
// append, free and free-count operations behind queue-style command and result ports.
// ----------------------------------------------------------------------------
// The table sits in one memory with one registered read and one write per
// cycle, and the engine runs one command at a time, so cost follows memory
// accesses. Write and unused opcodes need no table read and read needs one;
// seek reads one link per hop; free chain reads and clears each entry of
// the chain; count free scans min(active_entries, TABLE_ENTRIES) entries;
// append scans one entry a cycle up to the lowest free entry, then walks
// the chain one link per read to its end and links the new entry. The
// table has no reset value: software writes every entry before use.
// Commands queue two deep in front of the engine and results two deep
// behind it, so either side may stall independently. Write active_entries
// only while the block is idle.
// ----------------------------------------------------------------------------
module fat_chain_allocator import fca_pkg::*; #(
	parameter int TABLE_ENTRIES = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  opcode,
	input  logic [15:0] block_index,
	input  logic [15:0] hop_count,
	input  logic [15:0] entry_value,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  status,
	output logic [15:0] block_result,
	output logic [15:0] new_head,
	output logic [13:0] free_entries,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CMD_W = $bits(cmd_t);
	localparam int RES_W = $bits(res_t);

	logic [13:0]      active_q;
	logic             cfg_wr;
	cmd_t             front_cmd;
	logic             cq_push;
	logic             cq_full;
	logic             cq_empty;
	logic [CMD_W-1:0] cq_rdata;
	cmd_t             eng_cmd;
	logic             cmd_pop;
	logic             rq_full;
	logic             res_push;
	res_t             eng_res;
	logic [RES_W-1:0] rq_rdata;
	res_t             res_out;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_ACTIVE_ENTRIES) ? 32'(active_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (cfg_wr && paddr[2] == REG_ACTIVE_ENTRIES) begin
			active_q <= pwdata[13:0];
		end
	end

	fca_front #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_front (
		.push        (push),
		.opcode      (opcode),
		.block_index (block_index),
		.hop_count   (hop_count),
		.entry_value (entry_value),
		.q_full      (cq_full),
		.full        (full),
		.q_push      (cq_push),
		.cmd         (front_cmd)
	);

	fca_queue #(
		.WIDTH(CMD_W),
		.DEPTH(CMD_DEPTH)
	) u_cmd_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cq_push),
		.wr_data (front_cmd),
		.rd_en   (cmd_pop),
		.rd_data (cq_rdata),
		.full    (cq_full),
		.empty   (cq_empty)
	);

	assign eng_cmd = cmd_t'(cq_rdata);

	fca_engine #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.active_entries (active_q),
		.cmd_valid      (!cq_empty),
		.cmd            (eng_cmd),
		.cmd_pop        (cmd_pop),
		.res_room       (!rq_full),
		.res_push       (res_push),
		.res            (eng_res)
	);

	fca_queue #(
		.WIDTH(RES_W),
		.DEPTH(RES_DEPTH)
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (eng_res),
		.rd_en   (pop),
		.rd_data (rq_rdata),
		.full    (rq_full),
		.empty   (empty)
	);

	assign res_out      = res_t'(rq_rdata);
	assign status       = res_out.status;
	assign block_result = res_out.block_result;
	assign new_head     = res_out.new_head;
	assign free_entries = res_out.free_entries;

`ifndef NO_ASSERTIONS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !rq_full)
		else $error("result transfer into a full result queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cq_empty)
		else $error("command taken from an empty command queue");

	a_one_cmd_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> !cmd_pop)
		else $error("engine took back-to-back commands");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && paddr[2] == REG_ACTIVE_ENTRIES) |=> active_q == $past(pwdata[13:0]))
		else $error("active_entries not updated by configuration write");
`endif

endmodule
